// ===== src/u2pdf_pkg.sv =====
// Shared types and constants for the UTF-8 to PDF literal escaper.
package u2pdf_pkg;

	localparam int unsigned MAX_RES = 5;
	localparam int unsigned CNT_W   = 3;

	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [20:0] CP_REPLACE = 21'h00FFFD;
	localparam logic [20:0] CP_MAX     = 21'h10FFFF;

	typedef struct packed {
		logic       kind;
		logic [7:0] text_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_item;
		logic       closes_literal;
	} out_item_t;

	// All result bytes of one item; closes marks the last byte as ')'.
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [CNT_W-1:0]        count;
		logic                    closes;
	} burst_t;

	typedef struct packed {
		logic literal_open;
		logic output_stopped;
		logic pending;
	} dec_status_t;

endpackage

// ===== src/u2pdf_decoder.sv =====
// Decoder state and the combinational step that turns one item into a burst of bytes.
module u2pdf_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  u2pdf_pkg::in_item_t   item,
	input  logic                  advance,
	output u2pdf_pkg::burst_t     burst,
	output u2pdf_pkg::dec_status_t status
);
	import u2pdf_pkg::*;

	logic        open_q;
	logic        stopped_q;
	logic [1:0]  need_q;
	logic [1:0]  held_q;
	logic [20:0] pcp_q;

	logic        open_d;
	logic        stopped_d;
	logic [1:0]  need_d;
	logic [1:0]  held_d;
	logic [20:0] pcp_d;

	logic [CNT_W-1:0] n;
	logic [2:0]       nflush;
	logic [1:0]       held_inc;
	logic [20:0]      pcp_shift;
	logic             do_fresh;
	logic             cp_valid;
	logic [20:0]      cp;
	logic             emit_b;
	logic [7:0]       b;
	logic             is_cont;

	always_comb begin
		burst     = '0;
		n         = '0;
		open_d    = open_q;
		stopped_d = stopped_q;
		need_d    = need_q;
		held_d    = held_q;
		pcp_d     = pcp_q;
		do_fresh  = 1'b0;
		cp_valid  = 1'b0;
		cp        = '0;
		emit_b    = 1'b0;
		b         = '0;
		nflush    = (need_q != 2'd0) ? ({1'b0, held_q} + 3'd1) : 3'd0;
		held_inc  = held_q + 2'd1;
		pcp_shift = {pcp_q[14:0], item.text_byte[5:0]};
		is_cont   = (item.text_byte[7:6] == 2'b10);

		if (!open_q) begin
			if (n < CNT_W'(MAX_RES)) begin
				burst.bytes[n] = CH_OPEN;
			end
			n      = n + 1'b1;
			open_d = 1'b1;
		end

		if (item.kind == KIND_END) begin
			// flush held bytes, close, and return everything to reset
			for (int i = 0; i < 3; i++) begin
				if (3'(i) < nflush && n < CNT_W'(MAX_RES)) begin
					burst.bytes[n] = CH_QMARK;
					n = n + 1'b1;
				end
			end
			if (n < CNT_W'(MAX_RES)) begin
				burst.bytes[n] = CH_CLOSE;
			end
			n            = n + 1'b1;
			burst.closes = 1'b1;
			open_d       = 1'b0;
			stopped_d    = 1'b0;
			need_d       = '0;
			held_d       = '0;
			pcp_d        = '0;
		end else if (!stopped_q) begin
			if (need_q != 2'd0) begin
				if (is_cont) begin
					if (held_inc == need_q) begin
						need_d   = '0;
						held_d   = '0;
						pcp_d    = '0;
						cp_valid = 1'b1;
						cp       = (need_q == 2'd3 && pcp_shift > CP_MAX) ?
							CP_REPLACE : pcp_shift;
					end else begin
						held_d = held_inc;
						pcp_d  = pcp_shift;
					end
				end else begin
					for (int i = 0; i < 3; i++) begin
						if (3'(i) < nflush && n < CNT_W'(MAX_RES)) begin
							burst.bytes[n] = CH_QMARK;
							n = n + 1'b1;
						end
					end
					need_d   = '0;
					held_d   = '0;
					pcp_d    = '0;
					do_fresh = 1'b1;
				end
			end else begin
				do_fresh = 1'b1;
			end

			if (do_fresh) begin
				priority if (item.text_byte[7] == 1'b0) begin
					cp_valid = 1'b1;
					cp       = {13'd0, item.text_byte};
				end else if (item.text_byte[7:5] == 3'b110) begin
					need_d = 2'd1;
					held_d = '0;
					pcp_d  = {16'd0, item.text_byte[4:0]};
				end else if (item.text_byte[7:4] == 4'b1110) begin
					need_d = 2'd2;
					held_d = '0;
					pcp_d  = {17'd0, item.text_byte[3:0]};
				end else if (item.text_byte[7:3] == 5'b11110) begin
					need_d = 2'd3;
					held_d = '0;
					pcp_d  = {18'd0, item.text_byte[2:0]};
				end else begin
					cp_valid = 1'b1;
					cp       = CP_REPLACE;
				end
			end

			if (cp_valid) begin
				priority if (cp == 21'd0) begin
					// decoded zero: stop output until the end item
					stopped_d = 1'b1;
					need_d    = '0;
					held_d    = '0;
					pcp_d     = '0;
				end else if (cp == 21'd9 || cp == 21'd11) begin
					emit_b = 1'b1;
					b      = CH_SPACE;
				end else if (cp < 21'd32 && cp != 21'd10 && cp != 21'd13) begin
					emit_b = 1'b0;
				end else if (cp <= 21'd255) begin
					emit_b = 1'b1;
					b      = cp[7:0];
				end else begin
					emit_b = 1'b1;
					b      = CH_QMARK;
				end
			end

			if (emit_b) begin
				if (b == CH_BSL || b == CH_OPEN || b == CH_CLOSE) begin
					if (n < CNT_W'(MAX_RES)) begin
						burst.bytes[n] = CH_BSL;
					end
					n = n + 1'b1;
				end
				if (n < CNT_W'(MAX_RES)) begin
					burst.bytes[n] = b;
				end
				n = n + 1'b1;
			end
		end

		burst.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			stopped_q <= 1'b0;
			need_q    <= '0;
			held_q    <= '0;
			pcp_q     <= '0;
		end else if (advance) begin
			open_q    <= open_d;
			stopped_q <= stopped_d;
			need_q    <= need_d;
			held_q    <= held_d;
			pcp_q     <= pcp_d;
		end
	end

	assign status.literal_open   = open_q;
	assign status.output_stopped = stopped_q;
	assign status.pending        = (need_q != 2'd0);

endmodule

// ===== src/u2pdf_burst_out.sv =====
// Result register that holds one item's burst and hands it out a byte at a time.
module u2pdf_burst_out (
	input  logic                  clk,
	input  logic                  arst_n,
	input  u2pdf_pkg::burst_t     burst,
	input  logic                  load,
	output logic                  free,
	output logic                  lit_valid,
	input  logic                  lit_ready,
	output u2pdf_pkg::out_item_t  lit_item
);
	import u2pdf_pkg::*;

	logic                    valid_q;
	logic [MAX_RES-1:0][7:0] bytes_s2;
	logic [CNT_W-1:0]        count_s2;
	logic                    closes_s2;
	logic [CNT_W-1:0]        idx_q;
	logic                    is_last;

	assign is_last = (idx_q == count_s2 - 1'b1);
	assign free    = !valid_q || (lit_ready && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (free) begin
			valid_q <= load;
			idx_q   <= '0;
		end else if (lit_ready) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			bytes_s2  <= burst.bytes;
			count_s2  <= burst.count;
			closes_s2 <= burst.closes;
		end
	end

	assign lit_valid               = valid_q;
	assign lit_item.out_byte       = bytes_s2[idx_q];
	assign lit_item.last_of_item   = is_last;
	assign lit_item.closes_literal = is_last && closes_s2;

endmodule

// ===== src/utf8_to_pdf_literal_escaper_core.sv =====
// Top level of the UTF-8 to PDF string literal escaper.
// Takes one UTF-8 byte (or an end marker) per item and emits the bytes of a
// parenthesized PDF literal, one byte per output item. An item that yields
// one output byte or none does not hold up the input, so a plain text stream
// runs at one byte per cycle while lit_ready stays high; an item that yields
// n bytes (up to five: opening paren, flushed '?' bytes, escapes, closing
// paren) holds the single-byte output port while the result register drains.
// An accepted input passes the input register, then the result register.
module utf8_to_pdf_literal_escaper_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 text_valid,
	output logic                 text_ready,
	input  u2pdf_pkg::in_item_t  text_item,
	output logic                 lit_valid,
	input  logic                 lit_ready,
	output u2pdf_pkg::out_item_t lit_item
);
	import u2pdf_pkg::*;

	logic        valid_s1;
	in_item_t    item_s1;
	logic        advance;
	logic        burst_free;
	burst_t      burst;
	dec_status_t status;

	assign advance    = valid_s1 && burst_free;
	assign text_ready = !valid_s1 || burst_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			item_s1 <= text_item;
		end
	end

	u2pdf_decoder u_decoder (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.advance(advance),
		.burst  (burst),
		.status (status)
	);

	u2pdf_burst_out u_burst_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.burst    (burst),
		.load     (advance && burst.count != '0),
		.free     (burst_free),
		.lit_valid(lit_valid),
		.lit_ready(lit_ready),
		.lit_item (lit_item)
	);

	a_close_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		lit_valid && lit_item.closes_literal |-> lit_item.last_of_item)
		else $error("closing paren not marked as last byte of its item");

	a_stop_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		status.output_stopped |-> !status.pending)
		else $error("pending sequence held while output is stopped");

	a_stop_needs_open: assert property (@(posedge clk) disable iff (!arst_n)
		status.output_stopped || status.pending |-> status.literal_open)
		else $error("decoder state active with literal closed");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.kind == KIND_END |=> !status.literal_open)
		else $error("end item did not close the literal");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the UTF-8 to PDF string literal escaper core.
`timescale 1ns / 100ps

module testbench;
	import u2pdf_pkg::*;

	typedef struct {
		in_item_t item;
		bit       hold_for_drain;
	} text_entry_t;

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      text_valid = 1'b0;
	logic      text_ready;
	in_item_t  text_item  = '0;
	logic      lit_valid;
	logic      lit_ready  = 1'b0;
	out_item_t lit_item;

	text_entry_t text_pending_q[$];
	out_item_t   lit_expect_q[$];
	logic [7:0]  burst_q[$];

	// escaper state as seen from outside
	bit          lit_open;
	bit          out_stopped;
	logic [1:0]  need_cnt = '0;
	logic [1:0]  held_cnt = '0;
	logic [20:0] cp_acc   = '0;

	int unsigned error_count;
	int unsigned items_sent;
	int unsigned literals_closed;
	int unsigned bytes_checked;

	utf8_to_pdf_literal_escaper_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text_item (text_item),
		.lit_valid (lit_valid),
		.lit_ready (lit_ready),
		.lit_item  (lit_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic clear_held();
		need_cnt = '0;
		held_cnt = '0;
		cp_acc   = '0;
	endtask

	task automatic emit_code_point(input logic [20:0] cp);
		logic [7:0] b;
		if (cp == '0) begin
			out_stopped = 1'b1;
			clear_held();
			return;
		end
		if (cp == 21'd9 || cp == 21'd11)
			b = CH_SPACE;
		else if (cp < 21'd32 && cp != 21'd10 && cp != 21'd13)
			return;
		else if (cp <= 21'd255)
			b = cp[7:0];
		else
			b = CH_QMARK;
		if (b == CH_BSL || b == CH_OPEN || b == CH_CLOSE)
			burst_q.push_back(CH_BSL);
		burst_q.push_back(b);
	endtask

	// one '?' for the lead and one per continuation byte held
	task automatic flush_held();
		if (need_cnt != '0)
			repeat (int'(held_cnt) + 1) burst_q.push_back(CH_QMARK);
		clear_held();
	endtask

	task automatic start_byte(input logic [7:0] b);
		if (out_stopped)
			return;
		if (b[7] == 1'b0)
			emit_code_point({13'd0, b});
		else if (b[7:5] == 3'b110) begin
			need_cnt = 2'd1;
			held_cnt = '0;
			cp_acc   = {16'd0, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			need_cnt = 2'd2;
			held_cnt = '0;
			cp_acc   = {17'd0, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			need_cnt = 2'd3;
			held_cnt = '0;
			cp_acc   = {18'd0, b[2:0]};
		end else
			emit_code_point(CP_REPLACE);
	endtask

	// Work out the bytes one accepted item yields and queue them as expectations.
	task automatic escape_item(input in_item_t it);
		bit          closing;
		logic [20:0] cp;
		logic [1:0]  need;
		out_item_t   e;
		closing = 1'b0;
		burst_q.delete();
		if (!lit_open) begin
			burst_q.push_back(CH_OPEN);
			lit_open = 1'b1;
		end
		if (it.kind == KIND_END) begin
			flush_held();
			burst_q.push_back(CH_CLOSE);
			closing = 1'b1;
			lit_open    = 1'b0;
			out_stopped = 1'b0;
			clear_held();
			literals_closed++;
		end else if (!out_stopped) begin
			if (need_cnt != '0) begin
				if (it.text_byte[7:6] == 2'b10) begin
					cp_acc   = {cp_acc[14:0], it.text_byte[5:0]};
					held_cnt = held_cnt + 2'd1;
					if (held_cnt == need_cnt) begin
						cp   = cp_acc;
						need = need_cnt;
						clear_held();
						if (need == 2'd3 && cp > CP_MAX)
							cp = CP_REPLACE;
						emit_code_point(cp);
					end
				end else begin
					flush_held();
					start_byte(it.text_byte);
				end
			end else
				start_byte(it.text_byte);
		end
		foreach (burst_q[i]) begin
			e.out_byte       = burst_q[i];
			e.last_of_item   = (i == burst_q.size() - 1);
			e.closes_literal = closing && (i == burst_q.size() - 1);
			lit_expect_q.push_back(e);
		end
	endtask

	// Sender: advance to the next item once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
			text_item  <= '0;
		end else begin
			text_entry_t nxt;
			if (text_valid && text_ready) begin
				escape_item(text_item);
				items_sent++;
			end
			if (!text_valid || text_ready) begin
				if (text_pending_q.size() != 0
						&& ((items_sent >= 150 && items_sent < 260) || $urandom_range(99) >= 12)
						&& (!text_pending_q[0].hold_for_drain || lit_expect_q.size() == 0)) begin
					nxt = text_pending_q.pop_front();
					text_valid <= 1'b1;
					text_item  <= nxt.item;
				end else
					text_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall at random outside one quiet stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lit_ready <= 1'b0;
		else
			lit_ready <= (bytes_checked >= 250 && bytes_checked < 400)
				|| $urandom_range(99) >= 12;
	end

	always @(posedge clk) begin
		if (arst_n && lit_valid && lit_ready) begin
			out_item_t e;
			bytes_checked++;
			if (lit_expect_q.size() == 0)
				flag_error($sformatf("unexpected byte %h", lit_item.out_byte));
			else begin
				e = lit_expect_q.pop_front();
				if (lit_item.out_byte !== e.out_byte || lit_item.last_of_item !== e.last_of_item
						|| lit_item.closes_literal !== e.closes_literal)
					flag_error($sformatf("got byte %h last %b close %b, want %h %b %b",
						lit_item.out_byte, lit_item.last_of_item, lit_item.closes_literal,
						e.out_byte, e.last_of_item, e.closes_literal));
			end
		end
	end

	task automatic push_item(input logic kind, input logic [7:0] b, input bit drain = 1'b0);
		text_entry_t t;
		t.item.kind      = kind;
		t.item.text_byte = b;
		t.hold_for_drain = drain;
		text_pending_q.push_back(t);
	endtask

	task automatic push_text(input logic [7:0] b);
		push_item(KIND_TEXT, b);
	endtask

	task automatic push_end();
		push_item(KIND_END, 8'($urandom));
	endtask

	// Encode a value in len bytes; small values with len > 1 give overlong forms.
	task automatic push_encoded(input logic [20:0] c, input int len);
		case (len)
			1: push_text({1'b0, c[6:0]});
			2: begin
				push_text({3'b110, c[10:6]});
				push_text({2'b10, c[5:0]});
			end
			3: begin
				push_text({4'b1110, c[15:12]});
				push_text({2'b10, c[11:6]});
				push_text({2'b10, c[5:0]});
			end
			default: begin
				push_text({5'b11110, c[20:18]});
				push_text({2'b10, c[17:12]});
				push_text({2'b10, c[11:6]});
				push_text({2'b10, c[5:0]});
			end
		endcase
	endtask

	task automatic push_random_char();
		int          len;
		logic [20:0] c;
		len = $urandom_range(1, 4);
		case (len)
			1: c = ($urandom_range(99) < 2) ? 21'd0 : 21'($urandom_range(1, 127));
			2: c = ($urandom_range(99) < 60) ? 21'($urandom_range(8'h80, 8'hFF))
				: 21'($urandom_range(12'h100, 12'h7FF));
			3: c = 21'($urandom_range(16'h0800, 16'hFFFF));
			default: c = ($urandom_range(99) < 25) ? 21'($urandom_range(21'h110000, 21'h1FFFFF))
				: 21'($urandom_range(21'h010000, 21'h10FFFF));
		endcase
		// now and then an overlong form, a rare one of zero among them
		if ($urandom_range(99) < 6) begin
			c   = ($urandom_range(3) == 0) ? 21'd0 : 21'($urandom_range(1, 127));
			len = $urandom_range(2, 4);
		end
		push_encoded(c, len);
	endtask

	// A lead byte cut short by a fresh byte or by the end of text.
	task automatic push_broken_char();
		int len;
		len = $urandom_range(2, 4);
		case (len)
			2: push_text({3'b110, 5'($urandom)});
			3: push_text({4'b1110, 4'($urandom)});
			default: push_text({5'b11110, 3'($urandom)});
		endcase
		repeat ($urandom_range(0, len - 2)) push_text({2'b10, 6'($urandom)});
		if ($urandom_range(3) == 0)
			push_end();
		else if ($urandom_range(1) == 0)
			push_text(8'($urandom_range(1, 8'h7F)));
		else
			push_text(8'($urandom_range(8'hC0, 8'hFF)));
	endtask

	initial begin
		int unsigned r;
		// empty literal, plain and escaped characters, control codes, an invalid byte
		push_end();
		push_text(8'h41);
		push_text(CH_BSL);
		push_text(CH_OPEN);
		push_text(CH_CLOSE);
		push_text(8'h09);
		push_text(8'h0B);
		push_text(8'h0A);
		push_text(8'h01);
		push_text(8'hFF);
		// Latin-1 two-byte value, then a sequence broken by a plain byte
		push_text(8'hC3);
		push_text(8'hA9);
		push_text(8'hE2);
		push_text(8'h82);
		push_text(8'h41);
		// four-byte value past the Unicode range
		push_encoded(21'h110000, 4);
		// sequence cut off by the end of text
		push_text(8'hF0);
		push_text(8'h9F);
		push_text(8'h98);
		push_end();
		// overlong zero stops output until the end
		push_text(8'hC0);
		push_text(8'h80);
		push_text(8'h42);
		push_end();

		// drain everything before the random part starts
		push_item(KIND_TEXT, 8'h43, 1'b1);
		while (text_pending_q.size() < 450) begin
			if (text_pending_q.size() > 240 && text_pending_q.size() < 246)
				push_item(KIND_TEXT, 8'h44, 1'b1);
			r = $urandom_range(99);
			if (r < 8)
				push_end();
			else if (r < 70)
				push_random_char();
			else if (r < 85)
				push_broken_char();
			else
				push_text(8'($urandom));
		end
		push_end();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (text_pending_q.size() != 0 || text_valid || lit_expect_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d items closing %0d literals; checked %0d output bytes.",
			items_sent, literals_closed, bytes_checked);
		if (error_count == 0)
			$display("utf8_to_pdf_literal_escaper_core test passed");
		else
			$display("utf8_to_pdf_literal_escaper_core test failed");
		$finish;
	end

	initial begin
		#200000;
		$display("Timed out with %0d bytes still expected.", lit_expect_q.size());
		$display("utf8_to_pdf_literal_escaper_core test failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/u2pdf_pkg.sv
src/u2pdf_decoder.sv
src/u2pdf_burst_out.sv
src/utf8_to_pdf_literal_escaper_core.sv
tb/testbench.sv
